/* rtl/tga_image_stream_decoder_assert.svh */
// ---------------------------------------------------------------------------
// TGA decoder assertion macros
// Clocked assertion shorthands shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef TGA_IMAGE_STREAM_DECODER_ASSERT_SVH
`define TGA_IMAGE_STREAM_DECODER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define TGA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tga_pkg.sv */
// ---------------------------------------------------------------------------
// TGA decoder package
// Beat types, parser phases, result and error codes, header byte offsets.
// ---------------------------------------------------------------------------
package tga_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } tga_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  bytes_per_pixel;
    logic [1:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic        image_done;
  } tga_out_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_PACKET = 3'd2,
    PH_COLOUR = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TYPE    = 2'd1;
  localparam logic [1:0] ERR_DEPTH   = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;
  localparam logic [4:0] HDR_LEN       = 5'd18;

  localparam logic [7:0] TYPE_RGB      = 8'd2;
  localparam logic [7:0] TYPE_GRAY     = 8'd3;
  localparam logic [7:0] TYPE_RLE_RGB  = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;

  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [2:0] BPP_GRAY = 3'd1;
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBA = 3'd4;

endpackage

/* rtl/tga_image_stream_decoder.sv */
// ---------------------------------------------------------------------------
// TGA image stream decoder
// Results are registered; a result waits in the skid while out_stall holds the output.
// Throughput: one input beat per cycle while in_stall is low; each beat gives zero or one result.
// A two-deep output (register plus skid) keeps in_stall low unless both hold
// results; in_stall is a plain register output.
// Reset (rst_n low, synchronous) returns the parser to header byte 0 and
// empties the output stages.
// ---------------------------------------------------------------------------
`include "tga_image_stream_decoder_assert.svh"

module tga_image_stream_decoder
  import tga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tga_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tga_out_t out_result
);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  hidx_r, hidx_nxt;        // header byte index, saturates at 18
  logic [7:0]  id_left_r, id_left_nxt;  // ID field bytes still to skip
  logic        rle_r, rle_nxt;
  logic        gray_r, gray_nxt;
  logic [2:0]  pb_r, pb_nxt;            // bytes per pixel
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [31:0] pl_r, pl_nxt;            // pixels left in image
  logic [7:0]  ppl_r, ppl_nxt;          // pixels left in packet
  logic        pir_r, pir_nxt;          // current packet is a run
  logic [1:0]  cbi_r, cbi_nxt;          // colour byte index
  logic [31:0] ca_r, ca_nxt;            // colour assembly

  // Output register and skid
  tga_out_t out_r, skid_r;
  logic     out_valid_r, skid_valid_r;

  // State as seen by this beat: a start mark wipes the file context first
  phase_t      cur_phase;
  logic [4:0]  cur_hidx;
  logic [7:0]  cur_id_left;
  logic        cur_rle, cur_gray, cur_pir;
  logic [2:0]  cur_pb;
  logic [15:0] cur_width, cur_height;
  logic [31:0] cur_pl;
  logic [7:0]  cur_ppl;
  logic [1:0]  cur_cbi;
  logic [31:0] cur_ca;

  logic        accept;
  logic [7:0]  b;

  // Pixel datapath
  logic        pix_last;     // this byte completes a pixel
  logic [31:0] asm_new;
  logic [31:0] rgba;
  logic        run_pkt;
  logic        run_trunc;
  logic [7:0]  run_len;
  logic [31:0] pl_after;
  logic [7:0]  ppl_after;
  logic [1:0]  pix_err;
  logic        type_ok;
  logic        depth_ok;
  logic        img_empty;
  logic [31:0] img_pixels;

  // Result of this beat
  logic     res_valid;
  tga_out_t res;

  assign accept     = in_valid && !in_stall;
  assign b          = in_data.file_byte;
  assign in_stall   = skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_comb begin
    if (in_data.start_of_file) begin
      cur_phase   = PH_HEADER;
      cur_hidx    = '0;
      cur_id_left = '0;
      cur_rle     = 1'b0;
      cur_gray    = 1'b0;
      cur_pb      = '0;
      cur_width   = '0;
      cur_height  = '0;
      cur_pl      = '0;
      cur_ppl     = '0;
      cur_pir     = 1'b0;
      cur_cbi     = '0;
      cur_ca      = '0;
    end else begin
      cur_phase   = phase_r;
      cur_hidx    = hidx_r;
      cur_id_left = id_left_r;
      cur_rle     = rle_r;
      cur_gray    = gray_r;
      cur_pb      = pb_r;
      cur_width   = width_r;
      cur_height  = height_r;
      cur_pl      = pl_r;
      cur_ppl     = ppl_r;
      cur_pir     = pir_r;
      cur_cbi     = cbi_r;
      cur_ca      = ca_r;
    end
  end

  // Header checks
  assign type_ok    = (b == TYPE_RGB) || (b == TYPE_GRAY) ||
                      (b == TYPE_RLE_RGB) || (b == TYPE_RLE_GRAY);
  assign depth_ok   = cur_gray || (b == DEPTH_24) || (b == DEPTH_32);
  assign img_empty  = (cur_width == '0) || (cur_height == '0);
  assign img_pixels = 32'(cur_width) * 32'(cur_height);

  // Pixel assembly; BGR(A) byte order in, RGBA out
  assign pix_last = ({1'b0, cur_cbi} + 3'd1) >= cur_pb;
  assign asm_new  = cur_ca | (32'(b) << {cur_cbi, 3'b000});

  always_comb begin
    if (cur_gray || (cur_pb < BPP_RGB)) begin
      rgba = {24'h0, asm_new[7:0]};
    end else begin
      rgba = {(cur_pb == BPP_RGBA) ? asm_new[31:24] : 8'h00,
              asm_new[7:0], asm_new[15:8], asm_new[23:16]};
    end
  end

  // Run and pixel accounting
  assign run_pkt   = cur_rle && cur_pir;
  assign run_trunc = 32'(cur_ppl) > cur_pl;

  always_comb begin
    if (run_pkt) begin
      run_len   = run_trunc ? cur_pl[7:0] : cur_ppl;
      pl_after  = cur_pl - 32'(run_len);
      ppl_after = '0;
      pix_err   = run_trunc ? ERR_OVERRUN : ERR_NONE;
    end else begin
      run_len   = 8'd1;
      pl_after  = (cur_pl != '0) ? cur_pl - 32'd1 : cur_pl;
      ppl_after = (cur_rle && (cur_ppl != '0)) ? cur_ppl - 8'd1 : cur_ppl;
      pix_err   = (cur_rle && (pl_after == '0) && (ppl_after != '0)) ?
                  ERR_OVERRUN : ERR_NONE;
    end
  end

  // Next-state logic
  always_comb begin
    phase_nxt   = cur_phase;
    hidx_nxt    = cur_hidx;
    id_left_nxt = cur_id_left;
    rle_nxt     = cur_rle;
    gray_nxt    = cur_gray;
    pb_nxt      = cur_pb;
    width_nxt   = cur_width;
    height_nxt  = cur_height;
    pl_nxt      = cur_pl;
    ppl_nxt     = cur_ppl;
    pir_nxt     = cur_pir;
    cbi_nxt     = cur_cbi;
    ca_nxt      = cur_ca;

    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_hidx < HDR_LEN) begin
          hidx_nxt = cur_hidx + 5'd1;
        end
        unique case (cur_hidx)
          HDR_ID_LEN:    id_left_nxt = b;
          HDR_TYPE: begin
            if (type_ok) begin
              rle_nxt  = (b == TYPE_RLE_RGB) || (b == TYPE_RLE_GRAY);
              gray_nxt = (b == TYPE_GRAY) || (b == TYPE_RLE_GRAY);
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          HDR_WIDTH_LO:  width_nxt[7:0]   = b;
          HDR_WIDTH_HI:  width_nxt[15:8]  = b;
          HDR_HEIGHT_LO: height_nxt[7:0]  = b;
          HDR_HEIGHT_HI: height_nxt[15:8] = b;
          HDR_DEPTH: begin
            priority if (cur_gray) begin
              pb_nxt = BPP_GRAY;
            end else if (b == DEPTH_32) begin
              pb_nxt = BPP_RGBA;
            end else if (b == DEPTH_24) begin
              pb_nxt = BPP_RGB;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          HDR_LAST: begin
            pl_nxt  = img_pixels;
            cbi_nxt = '0;
            ca_nxt  = '0;
            priority if (img_empty) begin
              phase_nxt = PH_DONE;
            end else if (cur_id_left != '0) begin
              phase_nxt = PH_ID;
            end else if (cur_rle) begin
              phase_nxt = PH_PACKET;
            end else begin
              phase_nxt = PH_COLOUR;
            end
          end
          default: ;
        endcase
      end
      PH_ID: begin
        if (cur_id_left != '0) begin
          id_left_nxt = cur_id_left - 8'd1;
        end
        if (id_left_nxt == '0) begin
          priority if (cur_pl == '0) begin
            phase_nxt = PH_DONE;
          end else if (cur_rle) begin
            phase_nxt = PH_PACKET;
          end else begin
            phase_nxt = PH_COLOUR;
          end
        end
      end
      PH_PACKET: begin
        pir_nxt   = b[7];
        ppl_nxt   = {1'b0, b[6:0]} + 8'd1;
        cbi_nxt   = '0;
        ca_nxt    = '0;
        phase_nxt = PH_COLOUR;
      end
      PH_COLOUR: begin
        if (!pix_last) begin
          ca_nxt  = asm_new;
          cbi_nxt = cur_cbi + 2'd1;
        end else begin
          ca_nxt  = '0;
          cbi_nxt = '0;
          pl_nxt  = pl_after;
          ppl_nxt = ppl_after;
          priority if (pl_after == '0) begin
            phase_nxt = PH_DONE;
          end else if (cur_rle && (ppl_after == '0)) begin
            phase_nxt = PH_PACKET;
          end else begin
            phase_nxt = PH_COLOUR;
          end
        end
      end
      PH_DONE, PH_ERROR: ;
      default: ;
    endcase
  end

  // Result of this beat
  always_comb begin
    res_valid           = 1'b0;
    res                 = '0;
    res.image_width     = cur_width;
    res.image_height    = cur_height;
    unique case (cur_phase)
      PH_HEADER: begin
        if ((cur_hidx == HDR_TYPE) && !type_ok) begin
          res_valid      = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code = ERR_TYPE;
        end else if ((cur_hidx == HDR_DEPTH) && !depth_ok) begin
          res_valid      = 1'b1;
          res.result_kind = KIND_ERROR;
          res.error_code = ERR_DEPTH;
        end else if (cur_hidx == HDR_LAST) begin
          res_valid           = 1'b1;
          res.result_kind     = KIND_HEADER;
          res.bytes_per_pixel = cur_pb;
          res.image_done      = img_empty;
        end
      end
      PH_COLOUR: begin
        if (pix_last) begin
          res_valid           = 1'b1;
          res.result_kind     = KIND_PIXEL;
          res.bytes_per_pixel = cur_pb;
          res.error_code      = pix_err;
          res.red             = rgba[7:0];
          res.green           = rgba[15:8];
          res.blue            = rgba[23:16];
          res.alpha           = rgba[31:24];
          res.run_length      = run_len;
          res.image_done      = (pl_after == '0);
        end
      end
      PH_ID, PH_PACKET, PH_DONE, PH_ERROR: ;
      default: ;
    endcase
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hidx_r    <= '0;
      id_left_r <= '0;
      rle_r     <= 1'b0;
      gray_r    <= 1'b0;
      pb_r      <= '0;
      width_r   <= '0;
      height_r  <= '0;
      pl_r      <= '0;
      ppl_r     <= '0;
      pir_r     <= 1'b0;
      cbi_r     <= '0;
      ca_r      <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hidx_r    <= hidx_nxt;
      id_left_r <= id_left_nxt;
      rle_r     <= rle_nxt;
      gray_r    <= gray_nxt;
      pb_r      <= pb_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      pl_r      <= pl_nxt;
      ppl_r     <= ppl_nxt;
      pir_r     <= pir_nxt;
      cbi_r     <= cbi_nxt;
      ca_r      <= ca_nxt;
    end
  end

  // Output register with skid: skid fills only when the output is held
  logic pop, push;
  assign pop  = out_valid_r && !out_stall;
  assign push = accept && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // Checks
  `TGA_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r,
    "skid holds a beat while the output register is empty")
  `TGA_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r,
    "skid not drained after output beat taken")
  `TGA_ASSERT_ALWAYS(a_done_no_pixels, (phase_r != PH_DONE) || (pl_r == '0),
    "image marked done with pixels still outstanding")
  `TGA_ASSERT_ALWAYS(a_colour_depth,
    (phase_r != PH_COLOUR) || (pb_r == BPP_GRAY) || (pb_r == BPP_RGB) ||
    (pb_r == BPP_RGBA),
    "pixel data phase entered without a valid pixel size")

endmodule

/* bench/tga_image_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA image stream decoder testbench
// Streams generated TGA files into the decoder one byte per beat. A scoreboard
// decodes each accepted byte in parallel and checks every result field by
// field. Random idling on both channels, a long receiver hold-off and a drain
// pause exercise the handshake.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder_tb;
  import tga_pkg::*;

  localparam int RANDOM_BEATS = 1250;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int HOLD_AT      = 400;
  localparam int PAUSE_AT     = 800;
  localparam int STRETCH      = 150;   // beats per idling phase

  // --------------------------------------------------------------------------
  // Scoreboard: a parallel decoder plus the queue of results it has decoded
  // but not yet seen leave the block.
  // --------------------------------------------------------------------------
  class tga_decode_board;
    phase_t      phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_left;
    bit          rle;
    bit          gray;
    logic [2:0]  pix_bytes;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [31:0] px_left;
    logic [7:0]  pkt_left;
    bit          pkt_run;
    logic [1:0]  col_idx;
    logic [31:0] col_acc;
    tga_out_t    decoded_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_HEADER;
      hdr_idx   = '0;
      id_left   = '0;
      rle       = 1'b0;
      gray      = 1'b0;
      pix_bytes = '0;
      img_w     = '0;
      img_h     = '0;
      px_left   = '0;
      pkt_left  = '0;
      pkt_run   = 1'b0;
      col_idx   = '0;
      col_acc   = '0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void push_result(logic [1:0] kind, logic [2:0] bpp, logic [1:0] err,
                              logic [31:0] rgba, logic [7:0] run, logic done);
      tga_out_t r;
      r.result_kind     = kind;
      r.image_width     = img_w;
      r.image_height    = img_h;
      r.bytes_per_pixel = bpp;
      r.error_code      = err;
      r.red             = rgba[7:0];
      r.green           = rgba[15:8];
      r.blue            = rgba[23:16];
      r.alpha           = rgba[31:24];
      r.run_length      = run;
      r.image_done      = done;
      decoded_q.push_back(r);
    endfunction

    function phase_t data_phase();
      if (px_left == 0) return PH_DONE;
      return rle ? PH_PACKET : PH_COLOUR;
    endfunction

    function void header_byte(logic [7:0] b);
      logic [4:0] idx;
      idx = hdr_idx;
      if (hdr_idx < HDR_LEN) hdr_idx++;
      case (idx)
        HDR_ID_LEN: id_left = b;
        HDR_TYPE: begin
          if (b == TYPE_RGB || b == TYPE_GRAY || b == TYPE_RLE_RGB || b == TYPE_RLE_GRAY) begin
            rle  = (b == TYPE_RLE_RGB || b == TYPE_RLE_GRAY);
            gray = (b == TYPE_GRAY || b == TYPE_RLE_GRAY);
          end else begin
            phase = PH_ERROR;
            push_result(KIND_ERROR, 3'd0, ERR_TYPE, '0, '0, 1'b0);
          end
        end
        HDR_WIDTH_LO:  img_w[7:0]  = b;
        HDR_WIDTH_HI:  img_w[15:8] = b;
        HDR_HEIGHT_LO: img_h[7:0]  = b;
        HDR_HEIGHT_HI: img_h[15:8] = b;
        HDR_DEPTH: begin
          if (gray) pix_bytes = BPP_GRAY;
          else if (b == DEPTH_32) pix_bytes = BPP_RGBA;
          else if (b == DEPTH_24) pix_bytes = BPP_RGB;
          else begin
            phase = PH_ERROR;
            push_result(KIND_ERROR, 3'd0, ERR_DEPTH, '0, '0, 1'b0);
          end
        end
        HDR_LAST: begin
          px_left = {16'd0, img_w} * {16'd0, img_h};
          col_idx = '0;
          col_acc = '0;
          if (px_left == 0) phase = PH_DONE;
          else if (id_left != 0) phase = PH_ID;
          else phase = data_phase();
          push_result(KIND_HEADER, pix_bytes, ERR_NONE, '0, '0, px_left == 0);
        end
        default: ;
      endcase
    endfunction

    function void colour_byte(logic [7:0] b);
      logic [31:0] rgba;
      logic [1:0]  err;
      int          run;
      col_acc |= 32'(b) << (8 * col_idx);
      if (int'(col_idx) + 1 < int'(pix_bytes)) begin
        col_idx++;
        return;
      end
      col_idx = '0;
      err     = ERR_NONE;
      // file order is B,G,R(,A)
      if (gray || pix_bytes < BPP_RGB) rgba = {24'd0, col_acc[7:0]};
      else begin
        rgba = {8'd0, col_acc[7:0], col_acc[15:8], col_acc[23:16]};
        if (pix_bytes == BPP_RGBA) rgba[31:24] = col_acc[31:24];
      end
      col_acc = '0;
      if (rle && pkt_run) begin
        run = pkt_left;
        if (run > px_left) begin
          run = int'(px_left);
          err = ERR_OVERRUN;
        end
        px_left  -= run;
        pkt_left  = '0;
      end else begin
        run = 1;
        if (px_left != 0) px_left--;
        if (rle) begin
          if (pkt_left != 0) pkt_left--;
          if (px_left == 0 && pkt_left != 0) err = ERR_OVERRUN;
        end
      end
      if (px_left == 0) phase = PH_DONE;
      else if (rle && pkt_left == 0) phase = PH_PACKET;
      else phase = PH_COLOUR;
      push_result(KIND_PIXEL, pix_bytes, err, rgba, 8'(run), px_left == 0);
    endfunction

    function void decode_byte(tga_in_t beat);
      logic [7:0] b;
      b = beat.file_byte;
      if (beat.start_of_file) clear_state();
      case (phase)
        PH_HEADER: header_byte(b);
        PH_ID: begin
          if (id_left != 0) id_left--;
          if (id_left == 0) phase = data_phase();
        end
        PH_PACKET: begin
          pkt_run  = b[7];
          pkt_left = {1'b0, b[6:0]} + 8'd1;
          col_idx  = '0;
          col_acc  = '0;
          phase    = PH_COLOUR;
        end
        PH_COLOUR: colour_byte(b);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_result(tga_out_t got);
      tga_out_t want;
      if (decoded_q.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = decoded_q.pop_front();
      cmp("result_kind", got.result_kind, want.result_kind);
      cmp("image_width", got.image_width, want.image_width);
      cmp("image_height", got.image_height, want.image_height);
      cmp("bytes_per_pixel", got.bytes_per_pixel, want.bytes_per_pixel);
      cmp("error_code", got.error_code, want.error_code);
      cmp("red", got.red, want.red);
      cmp("green", got.green, want.green);
      cmp("blue", got.blue, want.blue);
      cmp("alpha", got.alpha, want.alpha);
      cmp("run_length", got.run_length, want.run_length);
      cmp("image_done", got.image_done, want.image_done);
    endtask

    task check_drained();
      if (decoded_q.size() != 0)
        report($sformatf("%0d decoded results never left the block", decoded_q.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block and its signals
  // --------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tga_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tga_out_t out_result;

  tga_decode_board sb;
  logic [7:0]      file_bytes[$];   // the file being streamed
  int              sender_idle_pct = 0;
  int              recv_stall_pct  = 0;
  bit              hold_req = 1'b0; // asks the receiver for the long hold-off
  int              quiet_cycles = 0;

  tga_image_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  always #5 clk = ~clk;

  // Both channels are sampled at the rising edge; stimulus moves at the falling
  // edge, so nothing here races the block's own registers.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.decode_byte(in_data);
      if (out_valid && !out_stall) sb.check_result(out_result);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog: the run is stuck if no beat moves for too long.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tga_image_stream_decoder_tb: errors");
    $finish;
  end

  // Receiver: random stalls per idling phase, plus one long hold-off on request
  // that runs while the sender keeps offering bytes.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // One byte beat. Called at a falling edge; returns at the falling edge after
  // the beat is taken. Valid only drops when the sender decides to idle.
  task send_beat(input logic [7:0] b, input logic sof);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{file_byte: b, start_of_file: sof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task send_file(input bit mark);
    foreach (file_bytes[i]) send_beat(file_bytes[i], mark && (i == 0));
  endtask

  // Random TGA file. Mostly well formed; a share carry a bad type, a bad depth,
  // an empty image or are cut short so the next start mark lands mid-file.
  task automatic build_file();
    int         shape;
    int         idsel;
    int         bpp;
    int         cnt;
    longint     rem;
    longint     take;
    logic [7:0] ftype;
    logic [7:0] depth;
    logic [7:0] id_len;
    logic [15:0] w;
    logic [15:0] h;
    bit         rle;
    bit         gray;
    bit         run;
    file_bytes.delete();
    shape = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       ftype = TYPE_RGB;
      1:       ftype = TYPE_GRAY;
      2:       ftype = TYPE_RLE_RGB;
      default: ftype = TYPE_RLE_GRAY;
    endcase
    if (shape < 6) begin
      do ftype = 8'($urandom_range(0, 255));
      while (ftype == TYPE_RGB || ftype == TYPE_GRAY ||
             ftype == TYPE_RLE_RGB || ftype == TYPE_RLE_GRAY);
    end else if (shape < 12) begin
      ftype = $urandom_range(0, 1) ? TYPE_RGB : TYPE_RLE_RGB;
    end
    rle  = (ftype == TYPE_RLE_RGB || ftype == TYPE_RLE_GRAY);
    gray = (ftype == TYPE_GRAY || ftype == TYPE_RLE_GRAY);
    if (gray) depth = 8'($urandom_range(0, 255));  // ignored for gray
    else if (shape >= 6 && shape < 12) begin
      do depth = 8'($urandom_range(0, 255));
      while (depth == DEPTH_24 || depth == DEPTH_32);
    end else depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    bpp = gray ? 1 : (depth == DEPTH_32 ? 4 : 3);

    idsel = $urandom_range(0, 19);
    if (idsel < 12) id_len = 8'd0;
    else if (idsel < 18) id_len = 8'($urandom_range(1, 4));
    else if (idsel == 18) id_len = 8'hFF;
    else id_len = 8'($urandom_range(0, 255));

    w = 16'($urandom_range(1, 6));
    h = 16'($urandom_range(1, 6));
    if (rle && $urandom_range(0, 4) == 0) begin
      w = 16'($urandom_range(16, 64));
      h = 16'($urandom_range(1, 3));
    end
    if (shape >= 12 && shape < 18) begin
      // empty image: one dimension zero, the other anything
      if ($urandom_range(0, 1)) begin
        w = 16'd0;
        h = 16'($urandom_range(0, 65535));
      end else begin
        w = 16'($urandom_range(0, 65535));
        h = 16'd0;
      end
    end else if (shape >= 18 && shape < 26 && $urandom_range(0, 1)) begin
      w = 16'($urandom_range(0, 65535));
      h = 16'($urandom_range(1, 65535));
    end

    file_bytes.push_back(id_len);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(ftype);
    repeat (9) file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    if (shape < 18) return;

    repeat (id_len) file_bytes.push_back(8'($urandom_range(0, 255)));
    rem = longint'(w) * longint'(h);
    // byte cap cuts the huge images and some of the longer RLE ones short
    while (rem > 0 && file_bytes.size() < 600) begin
      if (!rle) begin
        repeat (bpp) file_bytes.push_back(8'($urandom_range(0, 255)));
        rem--;
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          cnt = $urandom_range(0, 1) ? 128 : $urandom_range(1, 128);
          run = 1'b1;
        end else begin
          cnt = $urandom_range(1, (rem < 8) ? int'(rem) : 8);
          if ($urandom_range(0, 9) == 0) cnt += $urandom_range(0, 3);  // may overrun
          run = 1'($urandom_range(0, 1));
        end
        file_bytes.push_back({run, 7'(cnt - 1)});
        take = (cnt < rem) ? cnt : rem;
        if (run) repeat (bpp) file_bytes.push_back(8'($urandom_range(0, 255)));
        else repeat (take * bpp) file_bytes.push_back(8'($urandom_range(0, 255)));
        rem -= take;
      end
    end
    if (shape < 26) begin
      take = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > take) void'(file_bytes.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  beats_sent;
    bit  hold_done;
    bit  pause_done;
    bit  mark;
    sb         = new();
    beats_sent = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first file without a start mark, raw 32-bit 1x1 with extreme
    // channel values; then a marked file with a bad image type and id length 255.
    file_bytes = '{8'h00, 8'h00, TYPE_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                   DEPTH_32, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F};
    send_file(1'b0);
    file_bytes = '{8'hFF, 8'h00, 8'hFF};
    send_file(1'b1);

    // Random files, cycling through the idling phases.
    while (beats_sent < RANDOM_BEATS) begin
      case ((beats_sent / STRETCH) % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (!hold_done && beats_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && beats_sent >= PAUSE_AT) begin
        // sender waits for the block to drain completely
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      build_file();
      mark = ($urandom_range(0, 19) != 0);  // an unmarked file is a broken one
      send_file(mark);
      beats_sent += file_bytes.size();
      // trailing noise; ignored once an image is over
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) $display("tga_image_stream_decoder_tb: clean");
    else $display("tga_image_stream_decoder_tb: errors");
    $finish;
  end

endmodule
